// ----- rtl/life_automaton_torus_step_assert.svh -----
// ----------------------------------------------------------------------------
// life automaton assertion macros
// immediate-implication and next-cycle-implication property wrappers
// ----------------------------------------------------------------------------
`ifndef LIFE_AUTOMATON_TORUS_STEP_ASSERT_SVH
`define LIFE_AUTOMATON_TORUS_STEP_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define LIFE_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("life automaton assertion failed");

`define LIFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("life automaton assertion failed");

`else

`define LIFE_ASSERT_SAME(label, clk, rst, ante, cons)

`define LIFE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/lifets_pkg.sv -----
// ----------------------------------------------------------------------------
// lifets_pkg
// shared types and constants of the toroidal life grid
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lifets_pkg;

  localparam int ROW_BITS = 6;
  localparam int COL_BITS = 6;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef logic [3:0] count_t;

  localparam count_t BIRTH_COUNT = 4'd3;
  localparam count_t SURVIVE_LOW = 4'd2;

endpackage

// ----- rtl/lifets_ram.sv -----
// ----------------------------------------------------------------------------
// lifets_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lifets_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/lifets_row_unit.sv -----
// ----------------------------------------------------------------------------
// lifets_row_unit
// one grid row per cycle: wrapped neighbour counts and next generation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lifets_row_unit #(
  parameter int WIDTH = 64
) (
  input  logic [WIDTH-1:0]  top_row,
  input  logic [WIDTH-1:0]  mid_row,
  input  logic [WIDTH-1:0]  bot_row,
  output logic [WIDTH-1:0]  next_row,
  output lifets_pkg::count_t counts [WIDTH]
);

  import lifets_pkg::*;

  logic [WIDTH-1:0] top_l, top_r, mid_l, mid_r, bot_l, bot_r;

  // bit c of *_l holds column c-1, bit c of *_r holds column c+1, wrapped
  assign top_l = {top_row[WIDTH-2:0], top_row[WIDTH-1]};
  assign top_r = {top_row[0], top_row[WIDTH-1:1]};
  assign mid_l = {mid_row[WIDTH-2:0], mid_row[WIDTH-1]};
  assign mid_r = {mid_row[0], mid_row[WIDTH-1:1]};
  assign bot_l = {bot_row[WIDTH-2:0], bot_row[WIDTH-1]};
  assign bot_r = {bot_row[0], bot_row[WIDTH-1:1]};

  always_comb begin
    for (int c = 0; c < WIDTH; c++) begin
      counts[c] = count_t'(top_l[c]) + count_t'(top_row[c]) + count_t'(top_r[c])
                + count_t'(mid_l[c]) + count_t'(mid_r[c])
                + count_t'(bot_l[c]) + count_t'(bot_row[c]) + count_t'(bot_r[c]);
      next_row[c] = (counts[c] == BIRTH_COUNT)
                 || (mid_row[c] && (counts[c] == SURVIVE_LOW));
    end
  end

endmodule

// ----- rtl/life_automaton_torus_step.sv -----
// write and read: the rows above, at and below the cell are read, and the row is patched on a write
// step: all rows are read and the next generation goes to the other bank; cmd_stall holds until the result is out
// step rate is set by the single read port streaming the grid rows in order
// two banks swap roles after each step, so no copy-back pass is needed
// after reset a clearing pass writes GRID_HEIGHT rows to dead, one per cycle,
// with cmd_stall high throughout
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// life_automaton_torus_step
// toroidal B3/S23 life grid with write, read and generation step commands
// ----------------------------------------------------------------------------
`include "life_automaton_torus_step_assert.svh"

module life_automaton_torus_step #(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_HEIGHT = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  logic [1:0]         command,
  input  logic [5:0]         row,
  input  logic [5:0]         column,
  input  logic               cell_value,
  output logic               res_valid,
  input  logic               res_stall,
  output logic               cell_state,
  output lifets_pkg::count_t neighbour_count
);

  import lifets_pkg::*;

  localparam int RW    = $clog2(GRID_HEIGHT);
  localparam int CW    = $clog2(GRID_WIDTH);
  localparam int CNT_W = $clog2(GRID_HEIGHT + 3);
  localparam int AW    = (RW > ROW_BITS) ? RW : ROW_BITS;
  localparam int XW    = (CW > COL_BITS) ? CW : COL_BITS;

  localparam logic [RW-1:0]    LAST_ROW  = RW'(GRID_HEIGHT - 1);
  localparam logic [CNT_W-1:0] CLR_LAST  = CNT_W'(GRID_HEIGHT - 1);
  localparam logic [CNT_W-1:0] STEP_RDN  = CNT_W'(GRID_HEIGHT + 1);
  localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(GRID_HEIGHT + 2);
  localparam logic [CNT_W-1:0] STEP_WR0  = CNT_W'(3);
  localparam logic [CNT_W-1:0] ACC_MID   = CNT_W'(1);
  localparam logic [CNT_W-1:0] ACC_PATCH = CNT_W'(2);
  localparam logic [CNT_W-1:0] ACC_LAST  = CNT_W'(3);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_ACCESS = 5'b00100,
    S_STEP   = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic             bank;

  cmd_t             cmd_q;
  logic [RW-1:0]    row_q;
  logic [CW-1:0]    col_q;
  logic             val_q;
  logic [GRID_WIDTH-1:0] top_row, mid_row;
  logic             pend_state;
  count_t           pend_count;

  logic [AW-1:0]    row_ext;
  logic [XW-1:0]    col_ext;
  logic             in_range;
  logic [RW-1:0]    row_up, row_dn;
  logic [CNT_W-1:0] cnt_m1, cnt_m3;

  logic [RW-1:0]         rd_addr, wr_addr;
  logic                  wr_en, wr_bank;
  logic [GRID_WIDTH-1:0] wr_data, rd_a, rd_b, rd_data, patch_row, next_row;
  count_t                counts [GRID_WIDTH];

  assign row_ext  = AW'(row);
  assign col_ext  = XW'(column);
  assign in_range = (32'(row) < GRID_HEIGHT) && (32'(column) < GRID_WIDTH);
  assign row_up   = (row_q == '0) ? LAST_ROW : row_q - RW'(1);
  assign row_dn   = (row_q == LAST_ROW) ? '0 : row_q + RW'(1);
  assign cnt_m1   = cnt - CNT_W'(1);
  assign cnt_m3   = cnt - CNT_W'(3);
  assign rd_data  = bank ? rd_b : rd_a;
  assign cmd_stall = (state != S_IDLE);

  always_comb begin
    patch_row        = rd_data;
    patch_row[col_q] = val_q;
  end

  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    wr_bank = bank;
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cnt[RW-1:0];
      end
      S_STEP: begin
        if (cnt == '0) begin
          rd_addr = LAST_ROW;
        end else if (cnt >= STEP_RDN) begin
          rd_addr = '0;
        end else begin
          rd_addr = cnt_m1[RW-1:0];
        end
        wr_en   = (cnt >= STEP_WR0);
        wr_addr = cnt_m3[RW-1:0];
        wr_data = next_row;
        wr_bank = !bank;
      end
      S_ACCESS: begin
        if (cnt == '0) begin
          rd_addr = row_up;
        end else if (cnt == ACC_MID) begin
          rd_addr = row_q;
        end else begin
          rd_addr = row_dn;
        end
        wr_en   = (cmd_q == CMD_WRITE) && (cnt == ACC_PATCH);
        wr_addr = row_q;
        wr_data = patch_row;
      end
      S_IDLE, S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  lifets_ram #(
    .WIDTH (GRID_WIDTH),
    .DEPTH (GRID_HEIGHT)
  ) u_bank_a (
    .clk     (clk),
    .wr_en   (wr_en && !wr_bank),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_a)
  );

  lifets_ram #(
    .WIDTH (GRID_WIDTH),
    .DEPTH (GRID_HEIGHT)
  ) u_bank_b (
    .clk     (clk),
    .wr_en   (wr_en && wr_bank),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_b)
  );

  lifets_row_unit #(
    .WIDTH (GRID_WIDTH)
  ) u_row_unit (
    .top_row  (top_row),
    .mid_row  (mid_row),
    .bot_row  (rd_data),
    .next_row (next_row),
    .counts   (counts)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      bank      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && !res_stall && (state != S_OUT)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (cnt == CLR_LAST) begin
            cnt   <= '0;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            cnt <= '0;
            if (command == CMD_STEP) begin
              state <= S_STEP;
            end else if (((command == CMD_WRITE) || (command == CMD_READ)) && in_range) begin
              state <= S_ACCESS;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_ACCESS: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == ACC_LAST) begin
            state <= S_OUT;
          end
        end
        S_STEP: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == STEP_LAST) begin
            bank  <= !bank;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!res_valid || !res_stall) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && cmd_valid) begin
      cmd_q      <= cmd_t'(command);
      row_q      <= row_ext[RW-1:0];
      col_q      <= col_ext[CW-1:0];
      val_q      <= cell_value;
      pend_state <= 1'b0;
      pend_count <= '0;
    end
    if (((state == S_STEP) || (state == S_ACCESS)) && (cnt != '0)) begin
      top_row <= mid_row;
      mid_row <= ((state == S_ACCESS) && (cnt == ACC_PATCH) && (cmd_q == CMD_WRITE))
                 ? patch_row : rd_data;
    end
    if ((state == S_ACCESS) && (cnt == ACC_LAST)) begin
      pend_state <= mid_row[col_q];
      pend_count <= counts[col_q];
    end
    if ((state == S_OUT) && (!res_valid || !res_stall)) begin
      cell_state      <= pend_state;
      neighbour_count <= pend_count;
    end
  end

  `LIFE_ASSERT_SAME(a_step_writes_scratch, clk, rst, (state == S_STEP) && wr_en, wr_bank != bank)
  `LIFE_ASSERT_NEXT(a_step_flips_bank, clk, rst, (state == S_STEP) && (cnt == STEP_LAST), bank != $past(bank))
  `LIFE_ASSERT_SAME(a_access_write_once, clk, rst, (state == S_ACCESS) && wr_en, (cmd_q == CMD_WRITE) && (cnt == ACC_PATCH))
  `LIFE_ASSERT_NEXT(a_result_from_out, clk, rst, (state != S_OUT) && !res_valid, !res_valid)

endmodule
